[hdl/pdr_pkg.sv]
// Package for the planar dead-reckoning block: sequencer states, command and
// register codes, fixed-point constants, the arctangent table and saturation.
// No dependencies.
package pdr_pkg;

    localparam logic [1:0] CMD_SPEED   = 2'd0;
    localparam logic [1:0] CMD_HEADING = 2'd1;
    localparam logic [1:0] CMD_TICK    = 2'd2;
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    localparam logic [1:0] CFG_DEADBAND = 2'd0;
    localparam logic [1:0] CFG_MPS      = 2'd1;
    localparam logic [1:0] CFG_INVERT   = 2'd2;

    localparam int TRIG_ITERATIONS = 16;
    localparam int TRIG_TABLE_LEN  = 24;
    localparam int CORDIC_STEPS    =
        (TRIG_ITERATIONS < TRIG_TABLE_LEN) ? TRIG_ITERATIONS : TRIG_TABLE_LEN;

    // bit-serial engine lengths
    localparam int MUL_STEPS = 24;
    localparam int DIV_STEPS = 56;

    localparam logic [37:0] SPEED_SCALE  = 38'd200000000000;
    localparam logic [43:0] SPEED_DIV    = 44'd5729577951306;
    localparam logic [43:0] SPEED_DIV2   = 44'd11459155902612;
    localparam logic [22:0] SPEED_MAX    = 23'd8388607;
    localparam logic [30:0] RATE_K       = 31'd1171270634;
    localparam logic [31:0] RAD_SCALE    = 32'd3373259426;
    localparam logic [14:0] TRIG_DEN     = 15'd18000;
    localparam logic [15:0] TRIG_DEN2    = 16'd36000;
    localparam logic [16:0] TICK_DEN     = 17'd100000;
    localparam logic [17:0] TICK_DEN2    = 18'd200000;
    localparam logic signed [33:0] CORDIC_START = 34'sd652032874;

    typedef enum logic [15:0] {
        ST_IDLE    = 16'h0001,
        ST_SPD_MUL = 16'h0002,
        ST_SPD_DIV = 16'h0004,
        ST_SPD_SCL = 16'h0008,
        ST_HDG_MUL = 16'h0010,
        ST_HDG_DIV = 16'h0020,
        ST_TRG_MUL = 16'h0040,
        ST_TRG_DIV = 16'h0080,
        ST_CORDIC  = 16'h0100,
        ST_COS_SET = 16'h0200,
        ST_VX_MUL  = 16'h0400,
        ST_VY_MUL  = 16'h0800,
        ST_DX_MUL  = 16'h1000,
        ST_DX_DIV  = 16'h2000,
        ST_DY_MUL  = 16'h4000,
        ST_DY_DIV  = 16'h8000
    } pdr_state_t;

    // atan(2^-i) in Q30 radians
    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] v;
        begin
            case (i)
                5'd0:  v = 30'd843314857;
                5'd1:  v = 30'd497837829;
                5'd2:  v = 30'd263043837;
                5'd3:  v = 30'd133525159;
                5'd4:  v = 30'd67021687;
                5'd5:  v = 30'd33543516;
                5'd6:  v = 30'd16775851;
                5'd7:  v = 30'd8388437;
                5'd8:  v = 30'd4194283;
                5'd9:  v = 30'd2097149;
                5'd10: v = 30'd1048576;
                5'd11: v = 30'd524288;
                5'd12: v = 30'd262144;
                5'd13: v = 30'd131072;
                5'd14: v = 30'd65536;
                5'd15: v = 30'd32768;
                5'd16: v = 30'd16384;
                5'd17: v = 30'd8192;
                5'd18: v = 30'd4096;
                5'd19: v = 30'd2048;
                5'd20: v = 30'd1024;
                5'd21: v = 30'd512;
                5'd22: v = 30'd256;
                5'd23: v = 30'd128;
                default: v = 30'd0;
            endcase
            return v;
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        begin
            if (v > 34'sd2147483647)
                r = 32'sh7FFFFFFF;
            else if (v < -34'sd2147483648)
                r = 32'sh80000000;
            else
                r = v[31:0];
            return r;
        end
    endfunction

endpackage

[hdl/planar_dead_reckoning.sv]
// Planar dead-reckoning odometry: top level with its sequencer and a shared
// bit-serial multiplier, restoring divider and CORDIC rotator.
// Depends on pdr_pkg.
//
// One item is one event and gives one result item with the state after it.
// A speed command (cmd 0) rounds |speed|/57.2958 to whole steps and scales
// them by metres_per_step_q16; a heading sample (cmd 1) stores the heading and
// derives the yaw rate from the wrapped change over elapsed_ticks; a tick
// (cmd 2) rotates the forward speed by the heading with a CORDIC and adds
// velocity times dt to the saturating positions. Arithmetic runs one bit per
// cycle. A command inside the deadband, a first or zero-time heading sample
// and an unknown cmd finish without using the arithmetic engines. One item
// is worked on at a time; in_ready is high only while the sequencer is idle
// and no finished result waits to be posted, and the result register lets
// the next item in while the previous result still waits for out_ready.
// Configuration writes are always taken and must come only while idle.
module planar_dead_reckoning
    import pdr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         cmd,
    input  logic signed [15:0] speed_command,
    input  logic signed [16:0] heading_centideg,
    input  logic [16:0]        elapsed_ticks,

    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [16:0] heading_out,
    output logic signed [31:0] vel_x,
    output logic signed [31:0] vel_y,
    output logic signed [31:0] yaw_rate,
    output logic               rate_invalid
);

    pdr_state_t state_reg;
    logic       done_reg;       // result of the current item is ready to post

    // configuration
    logic [14:0] deadband_reg;
    logic [15:0] mps_reg;
    logic        invert_reg;

    // odometry state
    logic signed [31:0] pos_x_reg, pos_y_reg, vel_x_reg, vel_y_reg, yaw_reg;
    logic signed [16:0] hdg_reg;
    logic signed [23:0] fwd_reg;
    logic               seen_reg;

    // per-item scratch
    logic [16:0] elapsed_reg;
    logic        sgn_reg;
    logic        flip_reg;
    logic        invalid_reg;

    // serial engines
    logic [63:0] mul_a_reg, acc_reg;
    logic [23:0] mul_b_reg;
    logic [55:0] num_reg, quo_reg;
    logic [47:0] rem_reg, den_reg;
    logic [5:0]  cnt_reg;
    logic signed [33:0] cx_reg, cy_reg, cz_reg;

    // result register
    logic               out_valid_reg;
    logic signed [31:0] res_pos_x_reg, res_pos_y_reg, res_vel_x_reg, res_vel_y_reg;
    logic signed [31:0] res_yaw_reg;
    logic signed [16:0] res_hdg_reg;
    logic               res_invalid_reg;

    // ---------------- multiplier: one multiplier bit per cycle
    logic [63:0] mul_acc_next;
    logic        mul_last;
    assign mul_acc_next = acc_reg + (mul_b_reg[0] ? mul_a_reg : 64'd0);
    assign mul_last     = (cnt_reg == 6'(MUL_STEPS - 1));

    // ---------------- restoring divider: one quotient bit per cycle
    logic [48:0] div_trial, div_diff;
    logic        div_ge, div_last;
    logic [55:0] quo_next;
    logic [47:0] rem_next;
    assign div_trial = {rem_reg, num_reg[55]};
    assign div_diff  = div_trial - {1'b0, den_reg};
    assign div_ge    = (div_trial >= {1'b0, den_reg});
    assign rem_next  = div_ge ? div_diff[47:0] : div_trial[47:0];
    assign quo_next  = {quo_reg[54:0], div_ge};
    assign div_last  = (cnt_reg == 6'(DIV_STEPS - 1));

    // ---------------- speed command on entry
    logic signed [16:0] spd_ext;
    logic [16:0]        spd_mag;
    logic               spd_live;
    assign spd_ext  = {speed_command[15], speed_command};
    assign spd_mag  = speed_command[15] ? 17'(-spd_ext) : 17'(spd_ext);
    assign spd_live = (spd_mag > {2'b00, deadband_reg});

    // ---------------- heading change on entry, wrapped once
    logic signed [17:0] hd_diff, hd_wrap;
    logic [16:0]        hd_mag;
    always_comb
    begin
        hd_diff = 18'(heading_centideg) - 18'(hdg_reg);
        if (hd_diff > 18'sd18000)
            hd_wrap = hd_diff - 18'sd36000;
        else if (hd_diff < -18'sd18000)
            hd_wrap = hd_diff + 18'sd36000;
        else
            hd_wrap = hd_diff;
        hd_mag = hd_wrap[17] ? 17'(-hd_wrap) : 17'(hd_wrap);
    end

    // ---------------- trig argument: reduce mod 36000, fold into +-9000
    logic signed [17:0] tr_a, tr_b, tr_c, tr_d, tr_r;
    logic               tr_flip;
    logic [13:0]        tr_mag;
    always_comb
    begin
        tr_a = 18'(hdg_reg);
        tr_b = (tr_a < 18'sd0) ? tr_a + 18'sd36000 : tr_a;
        tr_c = (tr_b < 18'sd0) ? tr_b + 18'sd36000 : tr_b;
        tr_d = (tr_c >= 18'sd36000) ? tr_c - 18'sd36000 : tr_c;
        if (tr_d >= 18'sd18000)
            tr_d = tr_d - 18'sd36000;
        tr_flip = 1'b0;
        tr_r    = tr_d;
        if (tr_d > 18'sd9000)
        begin
            tr_r    = tr_d - 18'sd18000;
            tr_flip = 1'b1;
        end
        else if (tr_d < -18'sd9000)
        begin
            tr_r    = tr_d + 18'sd18000;
            tr_flip = 1'b1;
        end
        tr_mag = tr_r[17] ? 14'(-tr_r) : 14'(tr_r);
    end

    // ---------------- CORDIC rotation step
    logic signed [33:0] cd_dx, cd_dy, cd_at;
    logic               cd_last;
    assign cd_dx   = cy_reg >>> cnt_reg;
    assign cd_dy   = cx_reg >>> cnt_reg;
    assign cd_at   = signed'({4'b0000, atan_q30(cnt_reg[4:0])});
    assign cd_last = (cnt_reg == 6'(CORDIC_STEPS - 1));

    // ---------------- cosine / sine magnitudes and forward speed magnitude
    logic signed [33:0] cs_c, cs_s;
    logic [33:0]        cs_c_mag, cs_s_mag;
    logic [23:0]        fwd_mag;
    assign cs_c     = flip_reg ? -cx_reg : cx_reg;
    assign cs_s     = flip_reg ? -cy_reg : cy_reg;
    assign cs_c_mag = cs_c[33] ? 34'(-cs_c) : 34'(cs_c);
    assign cs_s_mag = cs_s[33] ? 34'(-cs_s) : 34'(cs_s);
    assign fwd_mag  = fwd_reg[23] ? 24'(-fwd_reg) : 24'(fwd_reg);

    // velocity = floor((speed * trig + 2^29) / 2^30)
    logic signed [57:0] vr_p, vr_sig, vr_sum;
    logic signed [31:0] vr_val;
    assign vr_p   = signed'({2'b00, mul_acc_next[55:0]});
    assign vr_sig = sgn_reg ? -vr_p : vr_p;
    assign vr_sum = vr_sig + 58'sd536870912;
    assign vr_val = 32'(vr_sum >>> 30);

    logic [31:0] vx_mag, vy_mag;
    assign vx_mag = vel_x_reg[31] ? 32'(-vel_x_reg) : 32'(vel_x_reg);
    assign vy_mag = vel_y_reg[31] ? 32'(-vel_y_reg) : 32'(vel_y_reg);

    // position step with saturation
    logic signed [33:0] dp_q, dp_d, px_sum, py_sum;
    assign dp_q   = signed'(quo_next[33:0]);
    assign dp_d   = sgn_reg ? -dp_q : dp_q;
    assign px_sum = 34'(pos_x_reg) + dp_d;
    assign py_sum = 34'(pos_y_reg) + dp_d;

    // yaw rate clamp
    logic        rt_big_n, rt_big_p;
    logic [31:0] rt_n;
    assign rt_big_n = (|quo_next[55:32]) || (quo_next[31:0] > 32'h80000000);
    assign rt_n     = rt_big_n ? 32'h80000000 : quo_next[31:0];
    assign rt_big_p = |quo_next[55:31];

    // speed scale clamp
    logic [22:0]        sp_m;
    logic signed [23:0] sp_v;
    assign sp_m = (|mul_acc_next[63:23]) ? SPEED_MAX : mul_acc_next[22:0];
    assign sp_v = (sgn_reg ^ invert_reg) ? -signed'({1'b0, sp_m}) : signed'({1'b0, sp_m});

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE) && !done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            deadband_reg  <= 15'd1;
            mps_reg       <= 16'd2032;
            invert_reg    <= 1'b1;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            vel_x_reg     <= '0;
            vel_y_reg     <= '0;
            yaw_reg       <= '0;
            hdg_reg       <= '0;
            fwd_reg       <= '0;
            seen_reg      <= 1'b0;
        end
        else
        begin
            // configuration writes
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_DEADBAND: deadband_reg <= cfg_data[14:0];
                    CFG_MPS:      mps_reg      <= cfg_data;
                    CFG_INVERT:   invert_reg   <= cfg_data[0];
                    default: ;
                endcase
            end

            // drop a taken result
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            // post the finished item once the result register is free
            if (done_reg && (!out_valid_reg || out_ready))
            begin
                done_reg        <= 1'b0;
                out_valid_reg   <= 1'b1;
                res_pos_x_reg   <= pos_x_reg;
                res_pos_y_reg   <= pos_y_reg;
                res_hdg_reg     <= hdg_reg;
                res_vel_x_reg   <= vel_x_reg;
                res_vel_y_reg   <= vel_y_reg;
                res_yaw_reg     <= yaw_reg;
                res_invalid_reg <= invalid_reg;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        elapsed_reg <= elapsed_ticks;
                        invalid_reg <= 1'b0;
                        acc_reg     <= '0;
                        cnt_reg     <= '0;
                        case (cmd)
                            CMD_SPEED:
                            begin
                                sgn_reg <= speed_command[15];
                                if (spd_live)
                                begin
                                    mul_a_reg <= 64'(SPEED_SCALE);
                                    mul_b_reg <= 24'(spd_mag);
                                    state_reg <= ST_SPD_MUL;
                                end
                                else
                                begin
                                    fwd_reg  <= '0;
                                    done_reg <= 1'b1;
                                end
                            end
                            CMD_HEADING:
                            begin
                                hdg_reg <= heading_centideg;
                                sgn_reg <= hd_wrap[17];
                                if (!seen_reg)
                                begin
                                    seen_reg <= 1'b1;
                                    yaw_reg  <= '0;
                                    done_reg <= 1'b1;
                                end
                                else if (elapsed_ticks == 17'd0)
                                begin
                                    invalid_reg <= 1'b1;
                                    done_reg    <= 1'b1;
                                end
                                else
                                begin
                                    mul_a_reg <= 64'(RATE_K);
                                    mul_b_reg <= 24'(hd_mag);
                                    state_reg <= ST_HDG_MUL;
                                end
                            end
                            CMD_TICK:
                            begin
                                sgn_reg   <= tr_r[17];
                                flip_reg  <= tr_flip;
                                mul_a_reg <= 64'(RAD_SCALE);
                                mul_b_reg <= 24'(tr_mag);
                                state_reg <= ST_TRG_MUL;
                            end
                            default: done_reg <= 1'b1;
                        endcase
                    end
                end

                ST_SPD_MUL, ST_HDG_MUL, ST_TRG_MUL, ST_VX_MUL, ST_VY_MUL,
                ST_DX_MUL, ST_DY_MUL, ST_SPD_SCL:
                begin
                    // one multiplier bit per cycle
                    acc_reg   <= mul_acc_next;
                    mul_a_reg <= {mul_a_reg[62:0], 1'b0};
                    mul_b_reg <= {1'b0, mul_b_reg[23:1]};
                    cnt_reg   <= cnt_reg + 6'd1;
                    if (mul_last)
                    begin
                        cnt_reg <= '0;
                        rem_reg <= '0;
                        quo_reg <= '0;
                        acc_reg <= '0;
                        case (state_reg)
                            ST_SPD_MUL:
                            begin
                                num_reg   <= 56'(mul_acc_next) + 56'(SPEED_DIV);
                                den_reg   <= 48'(SPEED_DIV2);
                                state_reg <= ST_SPD_DIV;
                            end
                            ST_SPD_SCL:
                            begin
                                fwd_reg   <= sp_v;
                                done_reg  <= 1'b1;
                                state_reg <= ST_IDLE;
                            end
                            ST_HDG_MUL:
                            begin
                                num_reg   <= {mul_acc_next[54:0], 1'b0}
                                             + 56'({elapsed_reg, 10'd0});
                                den_reg   <= 48'({elapsed_reg, 11'd0});
                                state_reg <= ST_HDG_DIV;
                            end
                            ST_TRG_MUL:
                            begin
                                num_reg   <= {mul_acc_next[54:0], 1'b0} + 56'(TRIG_DEN);
                                den_reg   <= 48'(TRIG_DEN2);
                                state_reg <= ST_TRG_DIV;
                            end
                            ST_VX_MUL:
                            begin
                                vel_x_reg <= vr_val;
                                sgn_reg   <= cs_s[33] ^ fwd_reg[23];
                                mul_a_reg <= 64'(cs_s_mag);
                                mul_b_reg <= fwd_mag;
                                state_reg <= ST_VY_MUL;
                            end
                            ST_VY_MUL:
                            begin
                                vel_y_reg <= vr_val;
                                sgn_reg   <= vel_x_reg[31];
                                mul_a_reg <= 64'(vx_mag);
                                mul_b_reg <= 24'(elapsed_reg);
                                state_reg <= ST_DX_MUL;
                            end
                            ST_DX_MUL, ST_DY_MUL:
                            begin
                                num_reg   <= {mul_acc_next[54:0], 1'b0} + 56'(TICK_DEN);
                                den_reg   <= 48'(TICK_DEN2);
                                state_reg <= (state_reg == ST_DX_MUL) ? ST_DX_DIV
                                                                      : ST_DY_DIV;
                            end
                            default: state_reg <= ST_IDLE;
                        endcase
                    end
                end

                ST_SPD_DIV, ST_HDG_DIV, ST_TRG_DIV, ST_DX_DIV, ST_DY_DIV:
                begin
                    // one quotient bit per cycle
                    rem_reg <= rem_next;
                    quo_reg <= quo_next;
                    num_reg <= {num_reg[54:0], 1'b0};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (div_last)
                    begin
                        cnt_reg <= '0;
                        acc_reg <= '0;
                        case (state_reg)
                            ST_SPD_DIV:
                            begin
                                mul_a_reg <= 64'(mps_reg);
                                mul_b_reg <= quo_next[23:0];
                                state_reg <= ST_SPD_SCL;
                            end
                            ST_HDG_DIV:
                            begin
                                if (sgn_reg)
                                    yaw_reg <= signed'(-rt_n);
                                else
                                    yaw_reg <= rt_big_p ? 32'sh7FFFFFFF
                                                        : signed'(quo_next[31:0]);
                                done_reg  <= 1'b1;
                                state_reg <= ST_IDLE;
                            end
                            ST_TRG_DIV:
                            begin
                                cz_reg    <= sgn_reg ? -signed'(quo_next[33:0])
                                                     : signed'(quo_next[33:0]);
                                cx_reg    <= CORDIC_START;
                                cy_reg    <= '0;
                                state_reg <= ST_CORDIC;
                            end
                            ST_DX_DIV:
                            begin
                                pos_x_reg <= sat32(px_sum);
                                sgn_reg   <= vel_y_reg[31];
                                mul_a_reg <= 64'(vy_mag);
                                mul_b_reg <= 24'(elapsed_reg);
                                state_reg <= ST_DY_MUL;
                            end
                            ST_DY_DIV:
                            begin
                                pos_y_reg <= sat32(py_sum);
                                done_reg  <= 1'b1;
                                state_reg <= ST_IDLE;
                            end
                            default: state_reg <= ST_IDLE;
                        endcase
                    end
                end

                ST_CORDIC:
                begin
                    // rotate toward zero residual angle
                    if (!cz_reg[33])
                    begin
                        cx_reg <= cx_reg - cd_dx;
                        cy_reg <= cy_reg + cd_dy;
                        cz_reg <= cz_reg - cd_at;
                    end
                    else
                    begin
                        cx_reg <= cx_reg + cd_dx;
                        cy_reg <= cy_reg - cd_dy;
                        cz_reg <= cz_reg + cd_at;
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cd_last)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_COS_SET;
                    end
                end

                ST_COS_SET:
                begin
                    sgn_reg   <= cs_c[33] ^ fwd_reg[23];
                    mul_a_reg <= 64'(cs_c_mag);
                    mul_b_reg <= fwd_mag;
                    acc_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_VX_MUL;
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign pos_x        = res_pos_x_reg;
    assign pos_y        = res_pos_y_reg;
    assign heading_out  = res_hdg_reg;
    assign vel_x        = res_vel_x_reg;
    assign vel_y        = res_vel_y_reg;
    assign yaw_rate     = res_yaw_reg;
    assign rate_invalid = res_invalid_reg;

endmodule
